// ===== hw/rtl/vrbs_pkg.sv =====
package vrbs_pkg;

    localparam int STORE_BYTES_DEF    = 1024;
    localparam int MAX_ELEM_BYTES_DEF = 64;
    localparam int HEADER_BYTES_DEF   = 4;

    // depth of the queue between front and back, and of the result buffer
    localparam int QUEUE_DEPTH = 4;
    localparam int OUT_DEPTH   = 4;
    localparam int OUT_CNT_W   = $clog2(OUT_DEPTH + 1);

    typedef enum logic [2:0] {
        CMD_PUSH  = 3'd0,
        CMD_POP   = 3'd1,
        CMD_PEEK  = 3'd2,
        CMD_CLEAR = 3'd3,
        CMD_QUERY = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_NO_ROOM  = 2'd2,
        ST_TOO_LONG = 2'd3
    } status_t;

    typedef struct packed {
        cmd_t       cmd;
        logic       first;      // first item of a push run
        logic [7:0] data;
        logic [6:0] len;
        logic       last;
    } op_t;

    typedef struct packed {
        status_t     status;
        logic [7:0]  out_byte;
        logic        byte_valid;
        logic        run_end;
        logic        is_empty;
        logic        no_room;
        logic [10:0] free_bytes;
    } res_t;

endpackage

// ===== hw/rtl/vrbs_ram.sv =====
module vrbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== hw/rtl/vrbs_fifo.sv =====
module vrbs_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    localparam int AW = $clog2(DEPTH),
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data,
    output logic [CW-1:0]    count
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             push, pop;

    assign in_ready  = (count_reg != CW'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign count     = count_reg;
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + AW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + AW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

// ===== hw/rtl/vrbs_front.sv =====
module vrbs_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic [2:0]     cmd,
    input  logic [7:0]     data_byte,
    input  logic [6:0]     length,
    input  logic           last,
    output logic           op_valid,
    input  logic           op_ready,
    output vrbs_pkg::op_t  op
);

    import vrbs_pkg::*;

    logic in_run_reg, in_run_next;
    logic known_cmd;
    logic accept;

    assign known_cmd = (cmd <= CMD_QUERY);
    assign in_ready  = op_ready;
    assign accept    = in_valid && in_ready;
    // unused codes are taken and dropped here
    assign op_valid  = in_valid && known_cmd;

    always_comb
    begin
        op.cmd   = cmd_t'(cmd);
        op.first = !in_run_reg;
        op.data  = data_byte;
        op.len   = length;
        op.last  = last;
    end

    always_comb
    begin
        in_run_next = in_run_reg;
        if (accept && known_cmd)
        begin
            in_run_next = (cmd == CMD_PUSH) && !last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_run_reg <= 1'b0;
        end
        else
        begin
            in_run_reg <= in_run_next;
        end
    end

endmodule

// ===== hw/rtl/vrbs_back.sv =====
module vrbs_back #(
    parameter int STORE_BYTES    = vrbs_pkg::STORE_BYTES_DEF,
    parameter int MAX_ELEM_BYTES = vrbs_pkg::MAX_ELEM_BYTES_DEF,
    parameter int HEADER_BYTES   = vrbs_pkg::HEADER_BYTES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           op_valid,
    output logic                           op_ready,
    input  vrbs_pkg::op_t                  op,
    output logic                           res_valid,
    input  logic                           res_ready,
    output vrbs_pkg::res_t                 res,
    input  logic [vrbs_pkg::OUT_CNT_W-1:0] res_count
);

    import vrbs_pkg::*;

    localparam int AW = $clog2(STORE_BYTES);
    localparam int TW = $clog2(STORE_BYTES + 1);
    localparam int HW = $clog2(HEADER_BYTES + 1);
    localparam int NW = (TW > 8) ? TW + 1 : 9;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_HWR    = 6'b000010,
        S_HRD    = 6'b000100,
        S_HEVAL  = 6'b001000,
        S_EMIT   = 6'b010000,
        S_RESULT = 6'b100000
    } state_t;

    state_t          state_reg, state_next;
    logic [TW-1:0]   top_reg, top_next;
    logic [6:0]      poff_reg, poff_next;
    logic [6:0]      plen_reg, plen_next;
    status_t         prej_reg, prej_next;
    logic [6:0]      len_reg, len_next;
    logic            is_pop_reg, is_pop_next;
    status_t         res_st_reg, res_st_next;
    logic [TW-1:0]   base_reg, base_next;
    logic [HW-1:0]   hidx_reg, hidx_next;
    logic [3:0][7:0] stored_reg, stored_next;
    logic [6:0]      cnt_reg, cnt_next;
    logic [6:0]      eidx_reg, eidx_next;
    logic            hcap_reg, hcap_next;
    logic [HW-1:0]   hcap_idx_reg, hcap_idx_next;
    logic            bcap_reg, bcap_next;
    logic            bcap_last_reg, bcap_last_next;

    logic            wr_en, rd_en;
    logic [AW-1:0]   wr_addr, rd_addr;
    logic [7:0]      wr_data, rd_data;

    // push run view with the first item folded in
    logic [6:0]      p_len, p_off;
    status_t         p_rej;
    logic [TW-1:0]   p_addr_w, p_base_w;
    logic [TW-1:0]   hwr_addr_w, hrd_addr_w, emit_addr_w;
    logic            store_empty;
    logic [31:0]     stored32;
    logic [6:0]      cnt_a, cnt_c;
    logic [32:0]     nt;
    logic [TW-1:0]   nt_sat;
    logic            credit;
    logic            r_noroom;
    logic [TW+10:0]  top_ext;

    vrbs_ram #(
        .WIDTH (8),
        .DEPTH (STORE_BYTES)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign store_empty = (top_reg == TW'(STORE_BYTES));
    assign top_ext     = {11'd0, top_reg};
    assign r_noroom    = (NW'(top_reg) < NW'(len_reg) + NW'(HEADER_BYTES));

    always_comb
    begin
        p_len = op.first ? op.len : plen_reg;
        p_off = op.first ? 7'd0 : poff_reg;
        p_rej = prej_reg;
        if (op.first)
        begin
            if (op.len > 7'(MAX_ELEM_BYTES))
            begin
                p_rej = ST_TOO_LONG;
            end
            else if (NW'(top_reg) < NW'(op.len) + NW'(HEADER_BYTES))
            begin
                p_rej = ST_NO_ROOM;
            end
            else
            begin
                p_rej = ST_OK;
            end
        end
    end

    assign p_addr_w    = top_reg - TW'(p_len) + TW'(p_off);
    assign p_base_w    = top_reg - TW'(p_len) - TW'(HEADER_BYTES);
    assign hwr_addr_w  = base_reg + TW'(hidx_reg);
    assign hrd_addr_w  = top_reg + TW'(hidx_reg);
    assign emit_addr_w = base_reg + TW'(eidx_reg);

    // header decode: count is min(stored, request, max element)
    assign stored32 = stored_reg;
    assign cnt_a    = (stored32 < 32'(len_reg)) ? stored32[6:0] : len_reg;
    assign cnt_c    = (cnt_a > 7'(MAX_ELEM_BYTES)) ? 7'(MAX_ELEM_BYTES) : cnt_a;
    assign nt       = 33'(base_reg) + {1'b0, stored32};
    assign nt_sat   = (nt > 33'(STORE_BYTES)) ? TW'(STORE_BYTES) : nt[TW-1:0];

    // room for the read in flight plus the one issued now
    assign credit = (int'(res_count) + int'(bcap_reg)) <= (OUT_DEPTH - 2);

    always_comb
    begin
        state_next     = state_reg;
        top_next       = top_reg;
        poff_next      = poff_reg;
        plen_next      = plen_reg;
        prej_next      = prej_reg;
        len_next       = len_reg;
        is_pop_next    = is_pop_reg;
        res_st_next    = res_st_reg;
        base_next      = base_reg;
        hidx_next      = hidx_reg;
        stored_next    = stored_reg;
        cnt_next       = cnt_reg;
        eidx_next      = eidx_reg;
        hcap_next      = 1'b0;
        hcap_idx_next  = hidx_reg;
        bcap_next      = 1'b0;
        bcap_last_next = 1'b0;
        op_ready       = 1'b0;
        wr_en          = 1'b0;
        wr_addr        = '0;
        wr_data        = '0;
        rd_en          = 1'b0;
        rd_addr        = '0;
        res_valid      = 1'b0;

        res.status     = res_st_reg;
        res.out_byte   = 8'd0;
        res.byte_valid = 1'b0;
        res.run_end    = 1'b1;
        res.is_empty   = store_empty;
        res.no_room    = r_noroom;
        res.free_bytes = top_ext[10:0];

        if (hcap_reg)
        begin
            for (int j = 0; j < 4; j++)
            begin
                if (int'(hcap_idx_reg) == j)
                begin
                    stored_next[j] = rd_data;
                end
            end
        end

        case (state_reg)
            S_IDLE:
            begin
                op_ready = 1'b1;
                if (op_valid)
                begin
                    len_next = op.len;
                    case (op.cmd)
                        CMD_PUSH:
                        begin
                            plen_next = p_len;
                            prej_next = p_rej;
                            poff_next = p_off;
                            if (p_rej == ST_OK && p_off < p_len)
                            begin
                                wr_en     = 1'b1;
                                wr_addr   = p_addr_w[AW-1:0];
                                wr_data   = op.data;
                                poff_next = p_off + 7'd1;
                            end
                            if (op.last)
                            begin
                                res_st_next = p_rej;
                                if (p_rej == ST_OK)
                                begin
                                    base_next  = p_base_w;
                                    hidx_next  = '0;
                                    state_next = S_HWR;
                                end
                                else
                                begin
                                    state_next = S_RESULT;
                                end
                            end
                        end
                        CMD_CLEAR:
                        begin
                            top_next    = TW'(STORE_BYTES);
                            res_st_next = ST_OK;
                            state_next  = S_RESULT;
                        end
                        CMD_QUERY:
                        begin
                            res_st_next = ST_OK;
                            state_next  = S_RESULT;
                        end
                        CMD_POP, CMD_PEEK:
                        begin
                            is_pop_next = (op.cmd == CMD_POP);
                            if (store_empty)
                            begin
                                res_st_next = ST_EMPTY;
                                state_next  = S_RESULT;
                            end
                            else
                            begin
                                base_next   = top_reg + TW'(HEADER_BYTES);
                                hidx_next   = '0;
                                stored_next = '0;
                                state_next  = S_HRD;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            S_HWR:
            begin
                // little-endian header, only the low byte can be nonzero
                wr_en   = 1'b1;
                wr_addr = hwr_addr_w[AW-1:0];
                wr_data = (hidx_reg == '0) ? {1'b0, plen_reg} : 8'd0;
                if (hidx_reg == HW'(HEADER_BYTES - 1))
                begin
                    top_next   = base_reg;
                    state_next = S_RESULT;
                end
                else
                begin
                    hidx_next = hidx_reg + HW'(1);
                end
            end

            S_HRD:
            begin
                if (hidx_reg != HW'(HEADER_BYTES))
                begin
                    rd_en         = 1'b1;
                    rd_addr       = hrd_addr_w[AW-1:0];
                    hcap_next     = 1'b1;
                    hcap_idx_next = hidx_reg;
                    hidx_next     = hidx_reg + HW'(1);
                end
                else
                begin
                    state_next = S_HEVAL;
                end
            end

            S_HEVAL:
            begin
                if (is_pop_reg)
                begin
                    top_next = nt_sat;
                end
                cnt_next  = cnt_c;
                eidx_next = 7'd0;
                if (cnt_c == 7'd0)
                begin
                    res_st_next = ST_OK;
                    state_next  = S_RESULT;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end

            S_EMIT:
            begin
                if (credit)
                begin
                    rd_en          = 1'b1;
                    rd_addr        = emit_addr_w[AW-1:0];
                    bcap_next      = 1'b1;
                    bcap_last_next = (eidx_reg + 7'd1 == cnt_reg);
                    eidx_next      = eidx_reg + 7'd1;
                    if (eidx_reg + 7'd1 == cnt_reg)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            S_RESULT:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // a byte read issued last cycle lands in the result buffer now
        if (bcap_reg)
        begin
            res_valid      = 1'b1;
            res.status     = ST_OK;
            res.out_byte   = rd_data;
            res.byte_valid = 1'b1;
            res.run_end    = bcap_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            top_reg       <= TW'(STORE_BYTES);
            poff_reg      <= '0;
            plen_reg      <= '0;
            prej_reg      <= ST_OK;
            hcap_reg      <= 1'b0;
            bcap_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            top_reg       <= top_next;
            poff_reg      <= poff_next;
            plen_reg      <= plen_next;
            prej_reg      <= prej_next;
            hcap_reg      <= hcap_next;
            bcap_reg      <= bcap_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg       <= len_next;
        is_pop_reg    <= is_pop_next;
        res_st_reg    <= res_st_next;
        base_reg      <= base_next;
        hidx_reg      <= hidx_next;
        stored_reg    <= stored_next;
        cnt_reg       <= cnt_next;
        eidx_reg      <= eidx_next;
        hcap_idx_reg  <= hcap_idx_next;
        bcap_last_reg <= bcap_last_next;
    end

endmodule

// ===== hw/rtl/variable_record_byte_stack.sv =====
// Byte stack of variable-length records, growing down from the top of a
// byte RAM. Each record sits above a little-endian length header.
// Input channel (in_valid/in_ready): cmd, data_byte, length, last.
//   A push is a run of cmd 0 items closed by last; pop, peek, clear and
//   query are single items. Codes 5 to 7 are taken and dropped.
// Output channel (out_valid/out_ready): one item per pop/peek byte, or a
//   single status item; run_end marks the final item of a command.
// A front stage tags push runs and feeds a 4-entry queue; the back stage
// runs the RAM (one write and one registered read port per cycle).
// Throughput: one push byte per cycle while the back stage is idle.
//   Closing a push writes the HEADER_BYTES header bytes, then the status
//   item. Pop/peek reads the header, then emits one byte per cycle while
//   the result buffer has room.
// Reset empties the store (free_bytes = STORE_BYTES); RAM contents are not
//   cleared. A stalled receiver fills the 4-entry result buffer (pop/peek
//   bytes stop one entry short), then the back stage holds, then the queue
//   fills and in_ready drops.
module variable_record_byte_stack #(
    parameter int STORE_BYTES    = vrbs_pkg::STORE_BYTES_DEF,
    parameter int MAX_ELEM_BYTES = vrbs_pkg::MAX_ELEM_BYTES_DEF,
    parameter int HEADER_BYTES   = vrbs_pkg::HEADER_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  cmd,
    input  logic [7:0]  data_byte,
    input  logic [6:0]  length,
    input  logic        last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [7:0]  out_byte,
    output logic        byte_valid,
    output logic        run_end,
    output logic        is_empty,
    output logic        no_room,
    output logic [10:0] free_bytes
);

    import vrbs_pkg::*;

    op_t                  fr_op, bk_op;
    logic                 fr_valid, fr_ready;
    logic                 bk_valid, bk_ready;
    res_t                 res_in, res_out;
    logic                 res_valid, res_ready;
    logic [OUT_CNT_W-1:0] res_count;

    vrbs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cmd       (cmd),
        .data_byte (data_byte),
        .length    (length),
        .last      (last),
        .op_valid  (fr_valid),
        .op_ready  (fr_ready),
        .op        (fr_op)
    );

    vrbs_fifo #(
        .WIDTH ($bits(op_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_op_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .in_data   (fr_op),
        .out_valid (bk_valid),
        .out_ready (bk_ready),
        .out_data  (bk_op),
        .count     ()
    );

    vrbs_back #(
        .STORE_BYTES    (STORE_BYTES),
        .MAX_ELEM_BYTES (MAX_ELEM_BYTES),
        .HEADER_BYTES   (HEADER_BYTES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (bk_valid),
        .op_ready  (bk_ready),
        .op        (bk_op),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res_in),
        .res_count (res_count)
    );

    vrbs_fifo #(
        .WIDTH ($bits(res_t)),
        .DEPTH (OUT_DEPTH)
    ) u_res_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (res_valid),
        .in_ready  (res_ready),
        .in_data   (res_in),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (res_out),
        .count     (res_count)
    );

    assign status     = res_out.status;
    assign out_byte   = res_out.out_byte;
    assign byte_valid = res_out.byte_valid;
    assign run_end    = res_out.run_end;
    assign is_empty   = res_out.is_empty;
    assign no_room    = res_out.no_room;
    assign free_bytes = res_out.free_bytes;

endmodule

// ===== hw/rtl/vrbs_checker.sv =====
module vrbs_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  status,
    input logic [7:0]  out_byte,
    input logic        byte_valid,
    input logic        run_end
);

    import vrbs_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result item dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_byte) && $stable(status))
        else $error("result item changed while stalled");

    // record bytes only come from a successful pop or peek
    a_byte_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && byte_valid |-> status == ST_OK)
        else $error("record byte with error status");

    // status-only items always close their command
    a_status_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !byte_valid |-> run_end)
        else $error("status item without run_end");

endmodule

bind variable_record_byte_stack vrbs_checker u_vrbs_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .out_byte   (out_byte),
    .byte_valid (byte_valid),
    .run_end    (run_end)
);

// ===== verif/variable_record_byte_stack_tb.sv =====
`timescale 1ns / 1ps

module variable_record_byte_stack_tb;

    import vrbs_pkg::*;

    localparam int STORE = STORE_BYTES_DEF;
    localparam int MAXLEN = MAX_ELEM_BYTES_DEF;
    localparam int HDR = HEADER_BYTES_DEF;
    localparam int RAND_ITEMS = 120;

    typedef struct {
        logic [2:0] cmd;
        logic [7:0] data;
        logic [6:0] len;
        logic       lst;
        int         phase;  // 0 none, 1 sender idles, 2 receiver stalls, 3 both
        bit         drain;  // hold until all results are back
    } stim_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [2:0]  cmd = '0;
    logic [7:0]  data_byte = '0;
    logic [6:0]  length = '0;
    logic        last = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  status;
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        run_end;
    logic        is_empty;
    logic        no_room;
    logic [10:0] free_bytes;

    variable_record_byte_stack i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .cmd        (cmd),
        .data_byte  (data_byte),
        .length     (length),
        .last       (last),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .out_byte   (out_byte),
        .byte_valid (byte_valid),
        .run_end    (run_end),
        .is_empty   (is_empty),
        .no_room    (no_room),
        .free_bytes (free_bytes)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    initial
    begin
        #20000000;
        $display("Verification failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stack predictor
    // ------------------------------------------------------------------
    logic [7:0] stack_mem [STORE];
    int         stack_top = STORE;
    int         run_offset = 0;
    int         run_length = 0;
    status_t    run_status = ST_OK;
    bit         run_open = 1'b0;

    res_t       expected_results [$];
    res_t       exp_head;
    int         n_errors = 0;

    function automatic logic [7:0] stack_rd(input int addr);
        return (addr < STORE) ? stack_mem[addr] : 8'h00;
    endfunction

    function automatic void add_expected(input status_t st, input logic [7:0] b,
                                         input logic v, input logic e, input int ln);
        res_t r;
        r.status     = st;
        r.out_byte   = b;
        r.byte_valid = v;
        r.run_end    = e;
        r.is_empty   = (stack_top == STORE);
        r.no_room    = (stack_top < ln + HDR);
        r.free_bytes = 11'(stack_top);
        expected_results.push_back(r);
    endfunction

    task automatic stack_step(input logic [2:0] c, input logic [7:0] d,
                              input logic [6:0] ln, input logic lst);
        longint stored;
        int     cnt;
        int     data0;
        int     base;
        int     i;
        if (c > CMD_QUERY)
            return;
        if (c == CMD_PUSH)
        begin
            if (!run_open)
            begin
                run_open   = 1'b1;
                run_offset = 0;
                run_length = ln;
                if (ln > MAXLEN)
                    run_status = ST_TOO_LONG;
                else if (stack_top < ln + HDR)
                    run_status = ST_NO_ROOM;
                else
                    run_status = ST_OK;
            end
            // bytes land below the current top while the run is open
            if (run_status == ST_OK && run_offset < run_length)
            begin
                if (stack_top - run_length + run_offset < STORE)
                    stack_mem[stack_top - run_length + run_offset] = d;
                run_offset++;
            end
            if (lst)
            begin
                run_open = 1'b0;
                if (run_status == ST_OK)
                begin
                    base = stack_top - run_length - HDR;
                    for (i = 0; i < HDR; i++)
                        if (base + i < STORE)
                            stack_mem[base + i] = (i < 4) ? 8'(run_length >> (8 * i)) : 8'h00;
                    stack_top = base;
                end
                add_expected(run_status, 8'h00, 1'b0, 1'b1, ln);
            end
            return;
        end
        run_open = 1'b0;
        if (c == CMD_CLEAR)
        begin
            stack_top = STORE;
            add_expected(ST_OK, 8'h00, 1'b0, 1'b1, ln);
        end
        else if (c == CMD_QUERY)
            add_expected(ST_OK, 8'h00, 1'b0, 1'b1, ln);
        else if (stack_top >= STORE)
            add_expected(ST_EMPTY, 8'h00, 1'b0, 1'b1, ln);
        else
        begin
            stored = 0;
            for (i = 0; i < HDR; i++)
                stored |= longint'(stack_rd(stack_top + i)) << (8 * i);
            cnt = (stored < ln) ? int'(stored) : int'(ln);
            if (cnt > MAXLEN)
                cnt = MAXLEN;
            data0 = stack_top + HDR;
            if (c == CMD_POP)
                stack_top = (data0 + stored > STORE) ? STORE : int'(data0 + stored);
            if (cnt == 0)
                add_expected(ST_OK, 8'h00, 1'b0, 1'b1, ln);
            else
                for (i = 0; i < cnt; i++)
                    add_expected(ST_OK, stack_rd(data0 + i), 1'b1, (i + 1 == cnt), ln);
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus generation, with a shadow of the stack to keep reads on
    // bytes that were written at some point
    // ------------------------------------------------------------------
    stim_t pending_items [$];
    int    gen_top = STORE;
    bit    gen_written [STORE];
    int    gen_records [$];     // stored lengths, top record first
    int    gen_phase = 0;
    bit    gen_drain = 1'b0;
    int    n_counted = 0;

    function automatic void add_item(input logic [2:0] c, input logic [7:0] d,
                                     input int ln, input logic lst);
        stim_t s;
        s.cmd   = c;
        s.data  = d;
        s.len   = 7'(ln);
        s.lst   = lst;
        s.phase = gen_phase;
        s.drain = gen_drain;
        gen_drain = 1'b0;
        pending_items.push_back(s);
        if (c <= CMD_QUERY)
            n_counted++;
    endfunction

    function automatic void gen_push(input int ln, input int nbytes, input bit closed,
                                     input bit extreme);
        bit ok;
        int i;
        ok = (ln <= MAXLEN) && (gen_top >= ln + HDR);
        for (i = 0; i < nbytes; i++)
        begin
            add_item(CMD_PUSH, extreme ? (i[0] ? 8'hFF : 8'h00) : 8'($urandom_range(255)),
                     (i == 0 || $urandom_range(1)) ? ln : $urandom_range(127),
                     closed && (i == nbytes - 1));
            if (ok && closed && i < ln)
                gen_written[gen_top - ln + i] = 1'b1;
            // dropped codes in the middle of a run
            if (!extreme && i < nbytes - 1 && $urandom_range(19) == 0)
                add_item(3'(5 + $urandom_range(2)), 8'($urandom_range(255)),
                         $urandom_range(127), 1'($urandom_range(1)));
        end
        if (ok && closed)
        begin
            for (i = 0; i < HDR; i++)
                gen_written[gen_top - ln - HDR + i] = 1'b1;
            gen_top -= ln + HDR;
            gen_records.push_front(ln);
        end
    endfunction

    function automatic void gen_cmd(input logic [2:0] c, input int ln);
        add_item(c, 8'($urandom_range(255)), ln, 1'($urandom_range(1)));
        if (c == CMD_POP && gen_records.size() > 0)
            gen_top += HDR + gen_records.pop_front();
        else if (c == CMD_CLEAR)
        begin
            gen_top = STORE;
            gen_records.delete();
        end
    endfunction

    // request size for pop/peek that never reaches an unwritten byte
    function automatic int read_len();
        int avail;
        if (gen_records.size() == 0)
            return $urandom_range(127);
        avail = 0;
        while (avail < gen_records[0] && gen_written[gen_top + HDR + avail])
            avail++;
        if (avail < gen_records[0])
            return $urandom_range(avail);
        return $urandom_range(1) ? $urandom_range(gen_records[0]) : $urandom_range(127);
    endfunction

    // ------------------------------------------------------------------
    // Driver, receiver, monitor
    // ------------------------------------------------------------------
    int n_accepted = 0;
    int n_presented = 0;
    int cur_phase = 0;
    int idle_pct;

    always @(negedge clk)
    begin
        if (rst_n && n_accepted == n_presented)
        begin
            if (pending_items.size() > 0)
            begin
                idle_pct = (pending_items[0].phase == 1) ? 59 :
                           (pending_items[0].phase == 3) ? 17 : 0;
                if ((!pending_items[0].drain || expected_results.size() == 0)
                    && $urandom_range(99) >= idle_pct)
                begin
                    cmd       <= pending_items[0].cmd;
                    data_byte <= pending_items[0].data;
                    length    <= pending_items[0].len;
                    last      <= pending_items[0].lst;
                    cur_phase <= pending_items[0].phase;
                    in_valid  <= 1'b1;
                    void'(pending_items.pop_front());
                    n_presented++;
                end
                else
                    in_valid <= 1'b0;
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        out_ready <= rst_n && ($urandom_range(99) >=
                     ((cur_phase == 2) ? 59 : (cur_phase == 3) ? 17 : 0));
    end

    task automatic check_field(input string name, input logic [10:0] want,
                               input logic [10:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            n_errors++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result item with no expectation waiting");
                n_errors++;
            end
            else
            begin
                exp_head = expected_results.pop_front();
                check_field("status", exp_head.status, status);
                check_field("out_byte", exp_head.out_byte, out_byte);
                check_field("byte_valid", exp_head.byte_valid, byte_valid);
                check_field("run_end", exp_head.run_end, run_end);
                check_field("is_empty", exp_head.is_empty, is_empty);
                check_field("no_room", exp_head.no_room, no_room);
                check_field("free_bytes", exp_head.free_bytes, free_bytes);
            end
        end
        if (rst_n && in_valid && in_ready)
        begin
            stack_step(cmd, data_byte, length, last);
            n_accepted <= n_accepted + 1;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        int seq;
        int pick;
        int ln;
        int nb;
        int i;
        for (i = 0; i < STORE; i++)
            stack_mem[i] = 8'h00;

        // directed items
        gen_cmd(CMD_POP, 5);                // pop and peek on an empty store
        gen_cmd(CMD_PEEK, 127);
        gen_cmd(CMD_QUERY, 0);
        gen_drain = 1'b1;
        gen_push(0, 1, 1'b1, 1'b1);         // zero-length record
        gen_cmd(CMD_PEEK, 7);
        gen_cmd(CMD_POP, 127);
        gen_push(3, 5, 1'b1, 1'b1);         // surplus bytes are dropped
        gen_cmd(CMD_PEEK, 0);
        gen_cmd(CMD_PEEK, 127);
        gen_cmd(CMD_POP, 2);
        gen_push(65, 2, 1'b1, 1'b1);        // over the length limit
        gen_push(4, 2, 1'b0, 1'b1);         // run cut short by a query
        gen_cmd(CMD_QUERY, 127);
        add_item(3'd5, 8'hFF, 127, 1'b1);
        add_item(3'd6, 8'h00, 0, 1'b0);
        add_item(3'd7, 8'hA5, 64, 1'b1);
        gen_cmd(CMD_CLEAR, 64);
        gen_cmd(CMD_POP, 0);
        gen_push(6, 2, 1'b1, 1'b1);         // short run over old bytes
        gen_cmd(CMD_PEEK, 127);

        // fill the store to the brim, then hit the room check
        gen_phase = 2;
        gen_drain = 1'b1;
        while (gen_top >= MAXLEN + HDR)
            gen_push(MAXLEN, 1, 1'b1, 1'b0);
        gen_push(MAXLEN, 2, 1'b1, 1'b0);
        gen_push(0, 1, 1'b1, 1'b0);
        gen_push(0, 1, 1'b1, 1'b0);
        gen_cmd(CMD_QUERY, $urandom_range(127));
        gen_cmd(CMD_PEEK, read_len());
        gen_cmd(CMD_POP, read_len());

        n_counted = 0;
        seq = 0;
        while (n_counted < RAND_ITEMS)
        begin
            gen_phase = (seq / 6) % 4;
            if (seq % 23 == 11)
                gen_drain = 1'b1;
            pick = $urandom_range(99);
            if (pick < 35)
            begin
                ln = ($urandom_range(3) == 0) ? $urandom_range(MAXLEN) : $urandom_range(12);
                nb = (ln == 0) ? 1 : ln;
                if ($urandom_range(9) == 0)
                    nb = ln + $urandom_range(1, 3);
                else if ($urandom_range(9) == 0 && ln > 0)
                    nb = $urandom_range(1, ln);
                gen_push(ln, nb, 1'b1, 1'b0);
            end
            else if (pick < 42)
            begin
                repeat ($urandom_range(3, 8))
                    gen_push($urandom_range(32, MAXLEN), 1, 1'b1, 1'b0);
            end
            else if (pick < 50)
            begin
                gen_push($urandom_range(127), $urandom_range(1, 4), 1'b0, 1'b0);
                pick = $urandom_range(3);
                if (pick < 2)
                    gen_cmd((pick == 0) ? CMD_POP : CMD_PEEK, read_len());
                else
                    gen_cmd((pick == 2) ? CMD_QUERY : CMD_CLEAR, $urandom_range(127));
            end
            else if (pick < 80)
                gen_cmd($urandom_range(1) ? CMD_POP : CMD_PEEK, read_len());
            else if (pick < 88)
                gen_cmd(CMD_QUERY, $urandom_range(127));
            else if (pick < 92)
                gen_cmd(CMD_CLEAR, $urandom_range(127));
            else if (pick < 96)
                add_item(3'(5 + $urandom_range(2)), 8'($urandom_range(255)),
                         $urandom_range(127), 1'($urandom_range(1)));
            else
                gen_push($urandom_range(MAXLEN + 1, 127), $urandom_range(1, 3), 1'b1, 1'b0);
            seq++;
        end

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_items.size() != 0 || n_accepted != n_presented
               || expected_results.size() != 0)
            @(posedge clk);
        repeat (32) @(posedge clk);

        if (n_errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/vrbs_pkg.sv
hw/rtl/vrbs_ram.sv
hw/rtl/vrbs_fifo.sv
hw/rtl/vrbs_front.sv
hw/rtl/vrbs_back.sv
hw/rtl/variable_record_byte_stack.sv
hw/rtl/vrbs_checker.sv
verif/variable_record_byte_stack_tb.sv
